[src/mdt_pkg.sv]
`default_nettype none

package mdt_pkg;

   // operation codes of an input word
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SET  = 2'd1;
   localparam logic [1:0] OP_EVAL = 2'd2;

   // motor states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_STOP = 2'd1;
   localparam logic [1:0] ST_POS  = 2'd2;
   localparam logic [1:0] ST_NEG  = 2'd3;

   // dead-time phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_START = 2'd1;
   localparam logic [1:0] PH_RUN   = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   // bridge commands
   localparam logic [1:0] DRV_OFF = 2'd0;
   localparam logic [1:0] DRV_POS = 2'd1;
   localparam logic [1:0] DRV_NEG = 2'd2;

   // dead-time register
   localparam int          DT_W     = 16;
   localparam logic [15:0] DT_RESET = 16'd100;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] target;
      logic       enable;
   } req_item_type;

   typedef struct packed {
      logic [1:0] present_state;
      logic [1:0] target_now;
      logic [1:0] drive;
      logic       dead_time_done;
   } rsp_item_type;

endpackage

`default_nettype wire

[src/motor_direction_dead_time_fsm_top.sv]
// Path: an accepted word sits in the input register and moves on to the result
// register, which drives the outputs, when that register is empty or being taken.
// Throughput: one word per cycle unless stalled; state updates once per advance.
// Reset: synchronous, active high; state returns to idle, phase to idle, counter
// to zero, dead time to 100 ticks, and both register stages empty.
`default_nettype none

module motor_direction_dead_time_fsm_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [1:0]  req_target,
   input  wire logic        req_enable,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_present_state,
   output logic [1:0]       rsp_target_now,
   output logic [1:0]       rsp_drive,
   output logic             rsp_dead_time_done,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata
);
   import mdt_pkg::*;

   logic              in_valid_ff;
   req_item_type      in_item_ff;
   logic              out_valid_ff;
   rsp_item_type      out_item_ff;
   rsp_item_type      result;
   logic [DT_W-1:0]   dead_time_ff;
   logic              advance;

   // word moves to the result register when it is empty or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // dead-time register
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_time_ff <= DT_RESET;
      end else if (csr_valid && csr_ready) begin
         dead_time_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff.operation <= req_operation;
         in_item_ff.target    <= req_target;
         in_item_ff.enable    <= req_enable;
      end
   end

   mdt_ctrl #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (in_item_ff),
      .dead_time (dead_time_ff),
      .result    (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_present_state  = out_item_ff.present_state;
   assign rsp_target_now     = out_item_ff.target_now;
   assign rsp_drive          = out_item_ff.drive;
   assign rsp_dead_time_done = out_item_ff.dead_time_done;

   // the bridge is driven only in a driving state
   a_drive_follows_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_drive == DRV_OFF) ==
                     (rsp_present_state == ST_IDLE || rsp_present_state == ST_STOP)))
      else $error("drive does not follow state");

   // driving only after a completed dead time
   a_drive_after_dead_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_present_state == ST_POS || rsp_present_state == ST_NEG))
      |-> rsp_dead_time_done)
      else $error("driving without completed dead time");

   // input held back only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output back-pressure");

   // both stages empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[src/mdt_ctrl.sv]
`default_nettype none

module mdt_ctrl #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire mdt_pkg::req_item_type     item,
   input  wire logic [mdt_pkg::DT_W-1:0]  dead_time,
   output mdt_pkg::rsp_item_type          result
);
   import mdt_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   logic [1:0]             motor_ff,  motor_in;
   logic [1:0]             target_ff, target_in;
   logic [1:0]             phase_ff,  phase_in;
   logic [COUNT_WIDTH-1:0] remain_ff, remain_in;
   logic                   over_ff,   over_in;
   logic [COUNT_WIDTH-1:0] load_val;
   logic [COUNT_WIDTH-1:0] remain_dec;

   // dead time fitted to the counter, saturating when it does not fit
   generate
      if (COUNT_WIDTH >= DT_W) begin : g_wide
         assign load_val = COUNT_WIDTH'(dead_time);
      end else begin : g_narrow
         assign load_val = (dead_time[DT_W-1:COUNT_WIDTH] != '0) ?
                           {COUNT_WIDTH{1'b1}} : dead_time[COUNT_WIDTH-1:0];
      end
   endgenerate

   assign remain_dec = remain_ff - CNT_ONE;

   // next state for the word at hand
   always_comb begin
      motor_in  = motor_ff;
      target_in = target_ff;
      phase_in  = phase_ff;
      remain_in = remain_ff;
      over_in   = over_ff;
      case (item.operation)
         OP_TICK: begin
            if (remain_ff != '0) begin
               remain_in = remain_dec;
               over_in   = (remain_dec == '0);
            end
         end
         OP_SET: begin
            target_in = item.target;
         end
         OP_EVAL: begin
            // forced stop while disabled
            if (!item.enable) begin
               if (motor_ff != ST_STOP) phase_in = PH_START;
               target_in = ST_STOP;
               motor_in  = ST_STOP;
            end
            case (motor_in)
               ST_IDLE: begin
                  if (target_in != ST_IDLE) begin
                     motor_in = ST_STOP;
                     phase_in = PH_START;
                  end
               end
               ST_STOP: begin
                  // dead-time phase runs first
                  if (phase_in == PH_IDLE || phase_in == PH_START) begin
                     if (load_val == '0) begin
                        over_in   = 1'b1;
                        remain_in = '0;
                     end else begin
                        over_in   = 1'b0;
                        remain_in = load_val;
                     end
                     phase_in = PH_RUN;
                  end
                  if (phase_in == PH_RUN && over_in) begin
                     remain_in = '0;
                     over_in   = 1'b0;
                     phase_in  = PH_DONE;
                  end
                  if (target_in == ST_IDLE) begin
                     motor_in = ST_IDLE;
                  end else if (target_in != ST_STOP && phase_in == PH_DONE) begin
                     motor_in = target_in;
                  end
               end
               default: begin
                  // driving in one direction
                  if (target_in == ST_IDLE) begin
                     motor_in = ST_IDLE;
                     phase_in = PH_START;
                  end else if (target_in != motor_in) begin
                     motor_in = ST_STOP;
                     phase_in = PH_START;
                  end
               end
            endcase
         end
         default: begin
            // unused code: no change
         end
      endcase
   end

   // result of this word, after the update
   always_comb begin
      result.present_state  = motor_in;
      result.target_now     = target_in;
      case (motor_in)
         ST_POS:  result.drive = DRV_POS;
         ST_NEG:  result.drive = DRV_NEG;
         default: result.drive = DRV_OFF;
      endcase
      result.dead_time_done = (phase_in == PH_DONE);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         motor_ff  <= ST_IDLE;
         target_ff <= ST_IDLE;
         phase_ff  <= PH_IDLE;
         remain_ff <= '0;
         over_ff   <= 1'b0;
      end else if (advance) begin
         motor_ff  <= motor_in;
         target_ff <= target_in;
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         over_ff   <= over_in;
      end
   end

endmodule

`default_nettype wire

[test/motor_drive_checker.sv]
`default_nettype none

module motor_drive_checker
   import mdt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [1:0]  req_target,
   input  wire logic        req_enable,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_present_state,
   input  wire logic [1:0]  rsp_target_now,
   input  wire logic [1:0]  rsp_drive,
   input  wire logic        rsp_dead_time_done,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_wdata,
   output int               mismatches,
   output int               awaiting
);

   // predicted copy of the controller
   logic [1:0]  run_state;
   logic [1:0]  goal_state;
   logic [1:0]  guard_phase;
   logic [15:0] guard_left;
   logic        guard_expired;
   logic [15:0] guard_ms;

   rsp_item_type expected_reports[$];
   int           fault_tally = 0;

   initial begin
      mismatches = 0;
      awaiting   = 0;
   end

   // apply one word to the predicted state and queue the report it gives
   task automatic predict_motor_word(input logic [1:0] op, input logic [1:0] tgt,
                                     input logic en);
      rsp_item_type rep;
      case (op)
         OP_TICK: begin
            if (guard_left != 16'd0) begin
               guard_left    = guard_left - 16'd1;
               guard_expired = (guard_left == 16'd0);
            end
         end
         OP_SET: goal_state = tgt;
         OP_EVAL: begin
            // enable low forces stop; restart dead time unless already stopped
            if (!en) begin
               if (run_state != ST_STOP) guard_phase = PH_START;
               goal_state = ST_STOP;
               run_state  = ST_STOP;
            end
            case (run_state)
               ST_IDLE: begin
                  if (goal_state != ST_IDLE) begin
                     run_state   = ST_STOP;
                     guard_phase = PH_START;
                  end
               end
               ST_STOP: begin
                  if (guard_phase == PH_IDLE || guard_phase == PH_START) begin
                     if (guard_ms == 16'd0) begin
                        guard_expired = 1'b1;
                        guard_left    = 16'd0;
                     end else begin
                        guard_left    = guard_ms;
                        guard_expired = 1'b0;
                     end
                     guard_phase = PH_RUN;
                  end
                  if (guard_phase == PH_RUN && guard_expired) begin
                     guard_left    = 16'd0;
                     guard_expired = 1'b0;
                     guard_phase   = PH_DONE;
                  end
                  if (goal_state == ST_IDLE)
                     run_state = ST_IDLE;
                  else if (goal_state != ST_STOP && guard_phase == PH_DONE)
                     run_state = goal_state;
               end
               default: begin
                  // driving: a goal of idle goes straight to idle; a change of direction passes through stop
                  if (goal_state == ST_IDLE) begin
                     run_state   = ST_IDLE;
                     guard_phase = PH_START;
                  end else if (goal_state != run_state) begin
                     run_state   = ST_STOP;
                     guard_phase = PH_START;
                  end
               end
            endcase
         end
         default: ;
      endcase
      rep.present_state  = run_state;
      rep.target_now     = goal_state;
      rep.drive          = (run_state == ST_POS) ? DRV_POS :
                           (run_state == ST_NEG) ? DRV_NEG : DRV_OFF;
      rep.dead_time_done = (guard_phase == PH_DONE);
      expected_reports.push_back(rep);
   endtask

   // watch the three channels at each edge
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type seen;
      if (reset) begin
         run_state     = ST_IDLE;
         goal_state    = ST_IDLE;
         guard_phase   = PH_IDLE;
         guard_left    = 16'd0;
         guard_expired = 1'b0;
         guard_ms      = DT_RESET;
         expected_reports.delete();
      end else begin
         if (csr_valid && csr_ready) guard_ms = csr_wdata;

         // result word: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            seen.present_state  = rsp_present_state;
            seen.target_now     = rsp_target_now;
            seen.drive          = rsp_drive;
            seen.dead_time_done = rsp_dead_time_done;
            if (expected_reports.size() == 0) begin
               fault_tally++;
               if (fault_tally <= 10)
                  $display("unexpected word: state %0d target %0d drive %0d done %0d",
                           seen.present_state, seen.target_now, seen.drive,
                           seen.dead_time_done);
            end else begin
               want = expected_reports.pop_front();
               if (want.present_state != seen.present_state ||
                   want.target_now != seen.target_now ||
                   want.drive != seen.drive ||
                   want.dead_time_done != seen.dead_time_done) begin
                  fault_tally++;
                  if (fault_tally <= 10)
                     $display({"mismatch: expected state %0d target %0d drive %0d done %0d,",
                               " got state %0d target %0d drive %0d done %0d"},
                              want.present_state, want.target_now, want.drive,
                              want.dead_time_done, seen.present_state, seen.target_now,
                              seen.drive, seen.dead_time_done);
               end
            end
         end

         // input word
         if (req_valid && !req_stall)
            predict_motor_word(req_operation, req_target, req_enable);
      end
      mismatches <= fault_tally;
      awaiting   <= expected_reports.size();
   end

endmodule

`default_nettype wire

[test/tb_motor_direction_dead_time_fsm_top.sv]
`default_nettype none

module tb_motor_direction_dead_time_fsm_top;
   import mdt_pkg::*;

   // operation code the block leaves unused
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_TICK;
   logic [1:0]  req_target = ST_IDLE;
   logic        req_enable = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_present_state;
   logic [1:0]  rsp_target_now;
   logic [1:0]  rsp_drive;
   logic        rsp_dead_time_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = 16'd0;

   int          mismatches;
   int          awaiting;
   int          words_sent = 0;
   int          hold_left = 0;
   logic [15:0] dead_ms = DT_RESET;
   bit          calm = 1'b0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   motor_direction_dead_time_fsm_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_target         (req_target),
      .req_enable         (req_enable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_present_state  (rsp_present_state),
      .rsp_target_now     (rsp_target_now),
      .rsp_drive          (rsp_drive),
      .rsp_dead_time_done (rsp_dead_time_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   motor_drive_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_target         (req_target),
      .req_enable         (req_enable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_present_state  (rsp_present_state),
      .rsp_target_now     (rsp_target_now),
      .rsp_drive          (rsp_drive),
      .rsp_dead_time_done (rsp_dead_time_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata),
      .mismatches         (mismatches),
      .awaiting           (awaiting)
   );

   // result side back-pressure: random stall bursts with random gaps between them
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         hold_left <= $urandom_range(0, 15);
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(0, 9);
      end
   end

   // offer one word, maybe after a gap, and wait until it is taken
   task automatic send_word(input logic [1:0] op, input logic [1:0] tgt, input logic en);
      if (!calm && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_target    <= tgt;
      req_enable    <= en;
      do @(posedge clock); while (req_stall);
      if (op != OP_SPARE) words_sent++;
   endtask

   // drop valid and let every outstanding result drain
   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_dead_time(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dead_ms = value;
   endtask

   // set a direction, wait out the dead time and drive
   task automatic drive_sequence();
      logic [1:0] dir;
      int         ticks;
      dir = ($urandom_range(0, 4) != 0) ? 2'($urandom_range(ST_POS, ST_NEG))
                                        : 2'($urandom_range(0, 3));
      send_word(OP_SET, dir, 1'($urandom));
      send_word(OP_EVAL, 2'($urandom), 1'b1);
      send_word(OP_EVAL, 2'($urandom), ($urandom_range(0, 11) != 0));
      ticks = (dead_ms > 200) ? $urandom_range(0, 20)
                              : int'(dead_ms) + $urandom_range(0, 2) - 1;
      repeat (ticks) send_word(OP_TICK, 2'($urandom), 1'($urandom));
      send_word(OP_EVAL, 2'($urandom), 1'b1);
      if ($urandom_range(0, 1)) send_word(OP_EVAL, 2'($urandom), 1'b1);
   endtask

   task automatic random_words(input int count);
      int         stop_at;
      int         pick;
      logic [1:0] op;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 9) < 6) begin
            drive_sequence();
         end else begin
            pick = $urandom_range(0, 9);
            op   = (pick < 4) ? OP_TICK : (pick < 7) ? OP_EVAL : (pick < 9) ? OP_SET
                                                                           : OP_SPARE;
            send_word(op, 2'($urandom_range(0, 3)), ($urandom_range(0, 9) != 0));
         end
      end
      drain_words();
   endtask

   initial begin
      logic [15:0] settings[8];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full direction cycle with a two-tick dead time
      write_dead_time(16'd2);
      send_word(OP_EVAL, ST_IDLE, 1'b1);
      send_word(OP_TICK, ST_NEG, 1'b0);
      send_word(OP_SET, ST_POS, 1'b1);
      send_word(OP_EVAL, ST_IDLE, 1'b1);
      send_word(OP_EVAL, ST_IDLE, 1'b1);
      send_word(OP_TICK, ST_IDLE, 1'b1);
      send_word(OP_TICK, ST_IDLE, 1'b1);
      send_word(OP_EVAL, ST_NEG, 1'b1);
      send_word(OP_SET, ST_NEG, 1'b0);
      send_word(OP_EVAL, ST_IDLE, 1'b1);
      send_word(OP_EVAL, ST_IDLE, 1'b1);
      send_word(OP_TICK, ST_STOP, 1'b0);
      send_word(OP_TICK, ST_STOP, 1'b0);
      send_word(OP_EVAL, ST_IDLE, 1'b1);
      // forced stop while driving, then while already stopped
      send_word(OP_EVAL, ST_POS, 1'b0);
      send_word(OP_SET, ST_POS, 1'b1);
      send_word(OP_EVAL, ST_IDLE, 1'b1);
      send_word(OP_TICK, ST_IDLE, 1'b1);
      send_word(OP_EVAL, ST_NEG, 1'b0);
      send_word(OP_SET, ST_IDLE, 1'b0);
      send_word(OP_EVAL, ST_IDLE, 1'b1);
      send_word(OP_SPARE, ST_NEG, 1'b1);
      send_word(OP_SET, ST_STOP, 1'b1);
      send_word(OP_EVAL, ST_STOP, 1'b1);
      drain_words();

      // random phases across dead-time settings, extremes included
      settings = '{16'd0, 16'hFFFF, 16'd1, 16'd3, DT_RESET,
                   16'($urandom_range(4, 8)), 16'd2, 16'($urandom_range(0, 5))};
      foreach (settings[i]) begin
         calm = (i == 3) || (i == 7);
         write_dead_time(settings[i]);
         random_words(240);
      end

      repeat (6) @(posedge clock);
      if (mismatches == 0 && awaiting == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hard limit on run length
   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
src/mdt_pkg.sv
src/mdt_ctrl.sv
src/motor_direction_dead_time_fsm_top.sv
test/motor_drive_checker.sv
test/tb_motor_direction_dead_time_fsm_top.sv
